/* rtl/core/inverted_page_table_core_macros.svh */
// Assertion macros shared by the inverted page table core.
`ifndef INVERTED_PAGE_TABLE_CORE_MACROS_SVH
`define INVERTED_PAGE_TABLE_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// Property that must hold at every clock edge outside reset.
`define IPT_ASSERT(lbl, clock, rst_n, prop, msg) \
	lbl: assert property (@(posedge clock) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked in the same cycle.
`define IPT_ASSERT_IMP(lbl, clock, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clock) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define IPT_ASSERT_NXT(lbl, clock, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clock) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define IPT_ASSERT(lbl, clock, rst_n, prop, msg)
`define IPT_ASSERT_IMP(lbl, clock, rst_n, ante, cons, msg)
`define IPT_ASSERT_NXT(lbl, clock, rst_n, ante, cons, msg)

`endif

`endif

/* rtl/core/ipt_pkg.sv */
// Types and constants of the inverted page table core.
package ipt_pkg;

	// Command codes carried in the kind field.
	localparam logic [1:0] KIND_TRANSLATE = 2'd0;
	localparam logic [1:0] KIND_LOAD      = 2'd1;
	localparam logic [1:0] KIND_FREE      = 2'd2;

	// Reset value of the frames-in-use register.
	localparam logic [8:0] FRAMES_RESET = 9'd256;

	// One command word.
	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] pid;
		logic [19:0] vpage;
		logic [11:0] offset;
		logic [8:0]  frame;
	} in_word_t;

	// One result word.
	typedef struct packed {
		logic        fault;
		logic [7:0]  frame_found;
		logic [19:0] phys_addr;
		logic [8:0]  probe_count;
	} out_word_t;

	// Word handed from cell to cell along the chain.
	typedef struct packed {
		logic       op_valid;
		in_word_t   cmd;
		logic       hit;
		logic [7:0] hit_frame;
		logic [8:0] steps;
	} chain_t;

endpackage

/* rtl/core/ipt_cell.sv */
// One frame cell: holds one table entry and acts on the word passing by.
module ipt_cell import ipt_pkg::*; #(
	parameter int INDEX = 0,
	parameter int CNT_W = 9
) (
	input  logic             clk,
	input  logic             arst_n,
	input  chain_t           word_in,
	input  logic [CNT_W-1:0] n_in,
	output chain_t           word_out,
	output logic [CNT_W-1:0] n_out
);

	logic        valid_q;
	logic [15:0] pid_q;
	logic [19:0] page_q;
	chain_t      word_q;
	logic [CNT_W-1:0] n_q;

	logic active;
	logic pid_match;
	logic entry_match;
	logic load_here;
	logic free_here;
	chain_t word_next;

	// Decode what the passing word does to this entry.
	always_comb begin
		active      = word_in.op_valid && (n_in > CNT_W'(INDEX));
		pid_match   = (pid_q == word_in.cmd.pid);
		entry_match = valid_q && pid_match && (page_q == word_in.cmd.vpage);
		load_here   = active && (word_in.cmd.kind == KIND_LOAD)
			&& (32'(word_in.cmd.frame) == 32'(INDEX));
		free_here   = active && (word_in.cmd.kind == KIND_FREE) && valid_q && pid_match;
		word_next   = word_in;
		if (active && (word_in.cmd.kind == KIND_TRANSLATE) && !word_in.hit && entry_match) begin
			word_next.hit       = 1'b1;
			word_next.hit_frame = 8'(INDEX);
			word_next.steps     = 9'(INDEX + 1);
		end
	end

	// Valid mark of the entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load_here) begin
			valid_q <= 1'b1;
		end else if (free_here) begin
			valid_q <= 1'b0;
		end
	end

	// Entry contents, written by a load.
	always_ff @(posedge clk) begin
		if (load_here) begin
			pid_q  <= word_in.cmd.pid;
			page_q <= word_in.cmd.vpage;
		end
	end

	// Hand the word to the next cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
			n_q    <= '0;
		end else begin
			word_q <= word_next;
			n_q    <= n_in;
		end
	end

	assign word_out = word_q;
	assign n_out    = n_q;

endmodule

/* rtl/core/inverted_page_table_core.sv */
// Top level of the inverted page table core: command intake, cell chain and result register.
//
// Each table entry lives in its own cell, and the cells form a chain that a command word walks
// through at one cell per cycle, so every entry sees commands in the order they were accepted.
// A new command is taken in every cycle (busy stays low), and a translate result passes through
// the register of each cell in turn and then through the result register. The
// result is shown for one cycle with result_valid high and cannot be held off. Load and free
// give no result. The frames-in-use register is always writable and applies to commands
// accepted after the write. The entry valid marks clear at reset; no clearing pass is needed.
`include "inverted_page_table_core_macros.svh"

module inverted_page_table_core import ipt_pkg::*; #(
	parameter int NUM_FRAMES = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_word_t  request,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic [8:0] cfg_data,
	output logic      result_valid,
	output out_word_t result
);

	localparam int CntW = $clog2(NUM_FRAMES + 1);

	logic [8:0]      frames_in_use_q;
	logic [CntW-1:0] n_clip;
	chain_t          head_w;
	chain_t          chain_w [NUM_FRAMES+1];
	logic [CntW-1:0] chain_n [NUM_FRAMES+1];
	chain_t          tail;
	logic            tail_translate;
	out_word_t       result_next;
	logic            result_valid_q;
	out_word_t       result_q;
	logic            fault_shown;
	logic            fault_clean;
	logic            hit_shown;
	logic            hit_addr_ok;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// Frames-in-use register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_in_use_q <= FRAMES_RESET;
		end else if (cfg_valid && cfg_ready) begin
			frames_in_use_q <= cfg_data;
		end
	end

	// Clip to the table size.
	always_comb begin
		if (32'(frames_in_use_q) > 32'(NUM_FRAMES)) begin
			n_clip = CntW'(NUM_FRAMES);
		end else begin
			n_clip = CntW'(frames_in_use_q);
		end
	end

	// Head of the chain.
	always_comb begin
		head_w.op_valid  = start && !busy;
		head_w.cmd       = request;
		head_w.hit       = 1'b0;
		head_w.hit_frame = 8'd0;
		head_w.steps     = 9'd0;
	end

	assign chain_w[0] = head_w;
	assign chain_n[0] = n_clip;

	// Row of frame cells.
	for (genvar i = 0; i < NUM_FRAMES; i++) begin : g_cell
		ipt_cell #(
			.INDEX (i),
			.CNT_W (CntW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.word_in  (chain_w[i]),
			.n_in     (chain_n[i]),
			.word_out (chain_w[i+1]),
			.n_out    (chain_n[i+1])
		);
	end

	// Form the result word from the tail of the chain.
	always_comb begin
		tail           = chain_w[NUM_FRAMES];
		tail_translate = tail.op_valid && (tail.cmd.kind == KIND_TRANSLATE);
		if (tail.hit) begin
			result_next.fault       = 1'b0;
			result_next.frame_found = tail.hit_frame;
			result_next.phys_addr   = {tail.hit_frame, tail.cmd.offset};
			result_next.probe_count = tail.steps;
		end else begin
			result_next.fault       = 1'b1;
			result_next.frame_found = 8'd0;
			result_next.phys_addr   = 20'd0;
			result_next.probe_count = 9'(chain_n[NUM_FRAMES]);
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= tail_translate;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= result_next;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Conditions watched on the result word.
	assign fault_shown = result_valid && result.fault;
	assign fault_clean = (result.frame_found == 8'd0) && (result.phys_addr == 20'd0);
	assign hit_shown   = result_valid && !result.fault;
	assign hit_addr_ok = (result.phys_addr[19:12] == result.frame_found);

	`IPT_ASSERT_NXT(a_translate_gives_result, clk, arst_n, tail_translate, result_valid, "no result")
	`IPT_ASSERT_NXT(a_no_spurious_result, clk, arst_n, !tail_translate, !result_valid, "stray result")
	`IPT_ASSERT_IMP(a_fault_zero, clk, arst_n, fault_shown, fault_clean, "fault word not zeroed")
	`IPT_ASSERT_IMP(a_hit_address, clk, arst_n, hit_shown, hit_addr_ok, "hit address off frame")

endmodule
